// ===== rtl/grid_ray_march_column_core_defines.svh =====
// Assertion helpers for the column core RTL.
`ifndef GRID_RAY_MARCH_COLUMN_CORE_DEFINES_SVH
`define GRID_RAY_MARCH_COLUMN_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/grm_pkg.sv =====
package grm_pkg;

    localparam int MAP_W_BITS  = 6;
    localparam int MAP_H_BITS  = 6;
    localparam int MAP_ADDR_W  = MAP_W_BITS + MAP_H_BITS;
    localparam int MAP_DEPTH   = 1 << MAP_ADDR_W;

    localparam int DIV_NUM_W   = 40;
    localparam int DIV_DEN_W   = 25;
    localparam int DIV_Q_W     = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_Q_W);

    localparam logic [2:0] CFG_PLAYER_X    = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y    = 3'd1;
    localparam logic [2:0] CFG_VIEW_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_FOV         = 3'd3;
    localparam logic [2:0] CFG_MARCH_STEP  = 3'd4;
    localparam logic [2:0] CFG_DEPTH_LIMIT = 3'd5;

    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_LEFT  = 3'd1;
    localparam logic [2:0] FACE_RIGHT = 3'd2;
    localparam logic [2:0] FACE_UP    = 3'd3;
    localparam logic [2:0] FACE_DOWN  = 3'd4;

    localparam logic [2:0] SHADE_FULL   = 3'd0;
    localparam logic [2:0] SHADE_DARK   = 3'd1;
    localparam logic [2:0] SHADE_MEDIUM = 3'd2;
    localparam logic [2:0] SHADE_LIGHT  = 3'd3;
    localparam logic [2:0] SHADE_BLANK  = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [MAP_ADDR_W-1:0] addr;
        logic                  wdata;
    } t_map_req;

    typedef struct packed {
        logic rdata;
        logic ready;
    } t_map_rsp;

endpackage

// ===== rtl/grm_divider.sv =====
module grm_divider
    import grm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_Q_W-1:0]   r_quot, n_quot;
    logic [DIV_NUM_W:0]   shifted;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb begin
        shifted = {{(DIV_NUM_W + 1 - DIV_DEN_W){1'b0}}, r_den} << r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_Q_W - 1);
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= shifted) begin
                n_rem = DIV_NUM_W'({1'b0, r_rem} - shifted);
                n_quot[r_cnt] = 1'b1;
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/grm_wall_map.sv =====
module grm_wall_map
    import grm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_map_req i_req,
    output t_map_rsp o_rsp
);

    logic                  r_mem [MAP_DEPTH];
    logic                  r_rdata;
    logic                  r_clearing;
    logic [MAP_ADDR_W-1:0] r_clr_addr;

    // After reset every cell is swept back to open floor, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rsp.rdata = r_rdata;
    assign o_rsp.ready = !r_clearing;

endmodule

// ===== rtl/grid_ray_march_column_core.sv =====
// After its request is accepted, a cast forms the ray angle and its two sines, then
// marches step by step (map read, then wall test), then runs the ceiling division and
// the output. A map write is done in the cycle that accepts it.
// One request at a time; the next is taken once the result sits in the output register.
// Sine and ceiling divisions share one serial divider. Reset is synchronous, active low,
// restores the defaults and clears the map.
`include "grid_ray_march_column_core_defines.svh"

module grid_ray_march_column_core
    import grm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [13:0] i_cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, lowest bit first: cell_x[5:0], cell_y[11:6], cell_is_wall[12],
    // screen_column[19:13], zero fill[23:20].
    input  logic [23:0] s_axis_tdata,
    // tuser: req_type[0].
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, lowest bit first: wall_distance[13:0], hit_face[16:14],
    // ceiling_row[26:17], floor_row[35:27], shade_code[38:36], near_wall[39],
    // column_edge[40], zero fill[47:41].
    output logic [47:0] m_axis_tdata
);

    // The cast sequencer. Each state holds a single step of the ray's work.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ANGLE = 13'b0000000000010,
        S_SINX  = 13'b0000000000100,
        S_WAITX = 13'b0000000001000,
        S_SINY  = 13'b0000000010000,
        S_WAITY = 13'b0000000100000,
        S_PREP  = 13'b0000001000000,
        S_STEP  = 13'b0000010000000,
        S_CHK   = 13'b0000100000000,
        S_FIN   = 13'b0001000000000,
        S_CEIL  = 13'b0010000000000,
        S_CWAIT = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [13:0] r_player_x, r_player_y, r_depth;
    logic [9:0]  r_view;
    logic [8:0]  r_fov;
    logic [7:0]  r_step;

    // Cast working registers.
    logic [6:0]        r_col;
    logic [9:0]        r_idx;
    logic              r_neg;
    logic signed [15:0] r_dx, r_dy;
    logic signed [24:0] r_sx, r_sy;
    logic signed [31:0] r_ax, r_ay;
    logic [14:0]       r_d;
    logic [13:0]       r_dist;
    logic [5:0]        r_cx, r_cy, r_tx, r_ty;
    logic [2:0]        r_face, r_prev_face;
    logic              r_cneg;
    logic signed [9:0] r_ceil;

    logic        r_out_valid;
    logic [47:0] r_out_data;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_map_req map_req;
    t_map_rsp map_rsp;

    grm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    grm_wall_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && map_rsp.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Ray angle in units of 1/262144 turn; the sine index is its top ten bits.
    logic signed [8:0]  ang_off;
    logic signed [19:0] ang_sum;
    assign ang_off = $signed({1'b0, r_col, 1'b1}) - 9'sd128;
    assign ang_sum = $signed({2'b00, r_view, 8'b0}) + ang_off * $signed({1'b0, r_fov});

    // Bhaskara sine over a half turn of 2048 units, quotient formed by the divider.
    // The y direction is a quarter turn ahead of the x direction.
    logic [11:0] sin_w;
    logic [10:0] sin_p;
    logic [20:0] sin_t;
    logic [24:0] sin_den;
    logic [39:0] sin_num;
    assign sin_w   = (r_state == S_SINY) ? ({r_idx, 2'b00} + 12'd1024) : {r_idx, 2'b00};
    assign sin_p   = sin_w[10:0];
    assign sin_t   = {10'b0, sin_p} * (21'd2048 - {10'b0, sin_p});
    assign sin_den = 25'd20971520 - {2'b00, sin_t, 2'b00};
    assign sin_num = {1'b0, sin_t, 18'b0} + {16'b0, sin_den[24:1]};

    logic signed [15:0] div_signed;
    assign div_signed = r_neg ? -$signed({1'b0, div_rsp.quot[14:0]})
                              :  $signed({1'b0, div_rsp.quot[14:0]});

    // One march step: advance distance and probe point, then find the cell.
    logic [7:0]         eff_step;
    logic [14:0]        n_d_step;
    logic signed [31:0] n_ax_step, n_ay_step;
    logic               probe_out;
    assign eff_step  = (r_step == 8'd0) ? 8'd1 : r_step;
    assign n_d_step  = r_d + {7'b0, eff_step};
    assign n_ax_step = r_ax + {{7{r_sx[24]}}, r_sx};
    assign n_ay_step = r_ay + {{7{r_sy[24]}}, r_sy};
    assign probe_out = n_ax_step[31] || n_ay_step[31] ||
                       (n_ax_step[30:28] != 3'b000) || (n_ay_step[30:28] != 3'b000);

    // Ceiling row: magnitude of 32*(d-512) over 2d, sign applied afterwards.
    logic        dist_ge;
    logic [13:0] dist_mag;
    assign dist_ge  = r_dist >= 14'd512;
    assign dist_mag = dist_ge ? (r_dist - 14'd512) : (14'd512 - r_dist);

    logic signed [14:0] ceil_full;
    assign ceil_full = r_cneg ? -$signed({1'b0, div_rsp.quot[13:0]})
                              :  $signed({1'b0, div_rsp.quot[13:0]});

    // Result fields.
    logic [16:0] d5, d3, d2;
    logic [18:0] d20, dep11;
    logic [2:0]  shade;
    logic        near;
    logic        edge_flag;
    logic signed [10:0] floor_full;
    assign d5    = {3'b0, r_dist} * 17'd5;
    assign d3    = {3'b0, r_dist} * 17'd3;
    assign d2    = {2'b0, r_dist, 1'b0};
    assign d20   = {5'b0, r_dist} * 19'd20;
    assign dep11 = {5'b0, r_depth} * 19'd11;
    assign near  = d20 < dep11;
    assign edge_flag = (r_col == 7'd0) || (r_col == 7'd127) || (r_face != r_prev_face);
    assign floor_full = 11'sd32 - {r_ceil[9], r_ceil};

    always_comb begin
        if (d5 <= {3'b0, r_depth}) begin
            shade = SHADE_FULL;
        end else if (d3 <= {3'b0, r_depth}) begin
            shade = SHADE_DARK;
        end else if (d2 <= {3'b0, r_depth}) begin
            shade = SHADE_MEDIUM;
        end else if (r_dist < r_depth) begin
            shade = SHADE_LIGHT;
        end else begin
            shade = SHADE_BLANK;
        end
    end

    logic out_slot;
    assign out_slot = !r_out_valid || m_axis_tready;

    // Sequencer next state and request outputs.
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.num   = sin_num;
        div_req.den   = sin_den;
        map_req.en    = 1'b0;
        map_req.we    = 1'b0;
        map_req.addr  = {s_axis_tdata[11:6], s_axis_tdata[5:0]};
        map_req.wdata = s_axis_tdata[12];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == REQ_WRITE) begin
                        map_req.en = 1'b1;
                        map_req.we = 1'b1;
                    end else begin
                        n_state = S_ANGLE;
                    end
                end
            end
            S_ANGLE: n_state = S_SINX;
            S_SINX: begin
                div_req.start = 1'b1;
                n_state       = S_WAITX;
            end
            S_WAITX: if (div_rsp.done) n_state = S_SINY;
            S_SINY: begin
                div_req.start = 1'b1;
                n_state       = S_WAITY;
            end
            S_WAITY: if (div_rsp.done) n_state = S_PREP;
            S_PREP: n_state = (r_depth != 14'd0) ? S_STEP : S_FIN;
            S_STEP: begin
                if (probe_out) begin
                    n_state = S_FIN;
                end else begin
                    map_req.en   = 1'b1;
                    map_req.addr = {n_ay_step[27:22], n_ax_step[27:22]};
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (map_rsp.rdata || (r_d >= {1'b0, r_depth})) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_FIN: n_state = S_CEIL;
            S_CEIL: begin
                if (r_dist == 14'd0) begin
                    n_state = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {21'b0, dist_mag, 5'b0};
                    div_req.den   = {10'b0, r_dist, 1'b0};
                    n_state       = S_CWAIT;
                end
            end
            S_CWAIT: if (div_rsp.done) n_state = S_OUT;
            S_OUT: if (out_slot) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_player_x  <= 14'd256;
            r_player_y  <= 14'd256;
            r_view      <= 10'd512;
            r_fov       <= 9'd64;
            r_step      <= 8'd26;
            r_depth     <= 14'd9216;
            r_prev_face <= FACE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_PLAYER_X:    r_player_x <= i_cfg_data;
                    CFG_PLAYER_Y:    r_player_y <= i_cfg_data;
                    CFG_VIEW_ANGLE:  r_view     <= i_cfg_data[9:0];
                    CFG_FOV:         r_fov      <= i_cfg_data[8:0];
                    CFG_MARCH_STEP:  r_step     <= i_cfg_data[7:0];
                    CFG_DEPTH_LIMIT: r_depth    <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_OUT) && out_slot) begin
                r_out_valid <= 1'b1;
                r_prev_face <= r_face;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= s_axis_tdata[19:13];
            end
            S_ANGLE: begin
                r_idx <= ang_sum[17:8];
            end
            S_SINX, S_SINY: begin
                r_neg <= sin_w[11];
            end
            S_WAITX: begin
                if (div_rsp.done) r_dx <= div_signed;
            end
            S_WAITY: begin
                if (div_rsp.done) r_dy <= div_signed;
            end
            S_PREP: begin
                r_sx   <= 25'(r_dx * $signed({1'b0, eff_step}));
                r_sy   <= 25'(r_dy * $signed({1'b0, eff_step}));
                r_ax   <= $signed({4'b0, r_player_x, 14'b0});
                r_ay   <= $signed({4'b0, r_player_y, 14'b0});
                r_d    <= 15'd0;
                r_cx   <= r_player_x[13:8];
                r_cy   <= r_player_y[13:8];
                r_face <= FACE_NONE;
            end
            S_STEP: begin
                r_ax <= n_ax_step;
                r_ay <= n_ay_step;
                r_tx <= n_ax_step[27:22];
                r_ty <= n_ay_step[27:22];
                // Leaving the map ends the march at the depth limit.
                r_d  <= probe_out ? {1'b0, r_depth} : n_d_step;
            end
            S_CHK: begin
                if (map_rsp.rdata) begin
                    if (r_tx > r_cx) begin
                        r_face <= FACE_LEFT;
                    end else if (r_tx < r_cx) begin
                        r_face <= FACE_RIGHT;
                    end else if (r_ty > r_cy) begin
                        r_face <= FACE_UP;
                    end else if (r_ty < r_cy) begin
                        r_face <= FACE_DOWN;
                    end else begin
                        r_face <= FACE_NONE;
                    end
                end else begin
                    r_cx <= r_tx;
                    r_cy <= r_ty;
                end
            end
            S_FIN: begin
                r_dist <= (r_d > {1'b0, r_depth}) ? r_depth : r_d[13:0];
            end
            S_CEIL: begin
                r_cneg <= !dist_ge;
                // A zero distance sits exactly on the saturation bound.
                r_ceil <= -10'sd479;
            end
            S_CWAIT: begin
                if (div_rsp.done) begin
                    r_ceil <= (ceil_full < -15'sd479) ? -10'sd479 : ceil_full[9:0];
                end
            end
            S_OUT: begin
                if (out_slot) begin
                    r_out_data <= {7'b0, edge_flag, near, shade, floor_full[8:0],
                                   r_ceil, r_face, r_dist};
                end
            end
            default: ;
        endcase
    end

    `GRM_ASSERT_NOW(a_ready_idle, s_axis_tready, (r_state == S_IDLE), "request taken while busy")
    `GRM_ASSERT_NEXT(a_step_chk, (r_state == S_STEP) && !probe_out, (r_state == S_CHK), "map read not checked")
    `GRM_ASSERT_NOW(a_dist_bound, (r_state == S_CEIL), (r_dist <= r_depth), "distance beyond depth limit")
    `GRM_ASSERT_NOW(a_div_done, div_rsp.done, ((r_state == S_WAITX) || (r_state == S_WAITY) || (r_state == S_CWAIT)), "divider result unexpected")

endmodule

// ===== sim/tb_grid_ray_march_column_core.sv =====
module tb_grid_ray_march_column_core;
    import grm_pkg::*;

    // A generous ceiling on the run.
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [13:0] distance;
        logic [2:0]  face;
        logic [9:0]  ceiling;
        logic [8:0]  floor_r;
        logic [2:0]  shade;
        logic        near;
        logic        edge_f;
    } t_column_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [13:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    grid_ray_march_column_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the block's registers and state, kept in request order.
    logic [13:0] eye_x, eye_y, depth_lim;
    logic [9:0]  facing;
    logic [8:0]  view_span;
    logic [7:0]  step_size;
    logic        wall_cells [0:4095];
    logic [2:0]  last_face;

    t_column_result pending_columns [$];
    int  mismatches = 0;
    int  tx_idle = 0;
    int  rx_idle = 0;
    int  hold_cycles = 0;
    bit  hold_off = 1'b0;
    longint cycles = 0;

    // Bhaskara sine, argument in quarter-table units, result in Q2.14.
    function automatic longint sine_q14(longint w);
        longint p, t, den, s;
        bit neg;
        w = w % 4096;
        neg = (w >= 2048);
        p = neg ? w - 2048 : w;
        t = p * (2048 - p);
        den = 5 * 2048 * 2048 - 4 * t;
        s = (16 * t * 16384 + den / 2) / den;
        return neg ? -s : s;
    endfunction

    // Marches one ray through the shadow map and works out the column it draws.
    function automatic t_column_result march_column(logic [6:0] col);
        t_column_result r;
        longint a, idx, dx, dy, stp, dlim, ray_len, cx, cy, px, py, tx, ty, ceil_row;
        logic [2:0] face;
        bit hit;
        a = longint'(facing) * 256 + (2 * longint'(col) + 1 - 128) * longint'(view_span);
        a = a % 262144;
        if (a < 0) a += 262144;
        idx = a * 1024 / 262144;
        dx = sine_q14(4 * idx);
        dy = sine_q14(4 * idx + 1024);
        stp = (step_size == 0) ? 1 : step_size;
        dlim = depth_lim;
        ray_len = 0;
        cx = eye_x >> 8;
        cy = eye_y >> 8;
        face = FACE_NONE;
        hit = 1'b0;
        while (!hit && ray_len < dlim) begin
            ray_len += stp;
            px = (longint'(eye_x) <<< 14) + dx * ray_len;
            py = (longint'(eye_y) <<< 14) + dy * ray_len;
            if (px < 0 || py < 0) begin
                ray_len = dlim;
                break;
            end
            tx = px >>> 22;
            ty = py >>> 22;
            if (tx >= 64 || ty >= 64) begin
                ray_len = dlim;
                break;
            end
            if (wall_cells[ty * 64 + tx]) begin
                if (tx > cx) face = FACE_LEFT;
                else if (tx < cx) face = FACE_RIGHT;
                else if (ty > cy) face = FACE_UP;
                else if (ty < cy) face = FACE_DOWN;
                hit = 1'b1;
            end else begin
                cx = tx;
                cy = ty;
            end
        end
        if (ray_len > dlim) ray_len = dlim;
        if (ray_len == 0) ceil_row = -479;
        else ceil_row = (32 * (ray_len - 512)) / (2 * ray_len);
        if (ceil_row < -479) ceil_row = -479;
        r.distance = ray_len[13:0];
        r.face = face;
        r.ceiling = ceil_row[9:0];
        r.floor_r = 9'(32 - ceil_row);
        if (5 * ray_len <= dlim) r.shade = SHADE_FULL;
        else if (3 * ray_len <= dlim) r.shade = SHADE_DARK;
        else if (2 * ray_len <= dlim) r.shade = SHADE_MEDIUM;
        else if (ray_len < dlim) r.shade = SHADE_LIGHT;
        else r.shade = SHADE_BLANK;
        r.near = (20 * ray_len < 11 * dlim);
        r.edge_f = (col == 0 || col == 127 || face != last_face);
        last_face = face;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Sends one request, with a random gap first, and records its expectation.
    task automatic send_request(logic kind, logic [23:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind == REQ_WRITE) wall_cells[{data[11:6], data[5:0]}] = data[12];
        else pending_columns.insert(pending_columns.size(), march_column(data[19:13]));
    endtask

    task automatic write_cell(int x, int y, bit wall);
        send_request(REQ_WRITE, {11'd0, wall, 6'(y), 6'(x)});
    endtask

    task automatic cast_column(int col);
        send_request(REQ_CAST, {4'd0, 7'(col), 13'd0});
    endtask

    // Lets the block finish all work before a register is touched.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_columns.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= 14'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PLAYER_X:    eye_x = 14'(value);
            CFG_PLAYER_Y:    eye_y = 14'(value);
            CFG_VIEW_ANGLE:  facing = 10'(value);
            CFG_FOV:         view_span = 9'(value);
            CFG_MARCH_STEP:  step_size = 8'(value);
            CFG_DEPTH_LIMIT: depth_lim = 14'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_view(int x, int y, int ang, int fov, int stp, int dep);
        wait_idle();
        write_register(CFG_PLAYER_X, x);
        write_register(CFG_PLAYER_Y, y);
        write_register(CFG_VIEW_ANGLE, ang);
        write_register(CFG_FOV, fov);
        write_register(CFG_MARCH_STEP, stp);
        write_register(CFG_DEPTH_LIMIT, dep);
    endtask

    // Results are sampled at the rising edge and checked field by field.
    always @(posedge i_clk) begin
        t_column_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[13:0], m_axis_tdata[16:14], m_axis_tdata[26:17],
                   m_axis_tdata[35:27], m_axis_tdata[38:36], m_axis_tdata[39],
                   m_axis_tdata[40]};
            if (pending_columns.size() == 0) begin
                report_mismatch("unexpected result, outstanding count", 1, 0);
            end else begin
                want = pending_columns.pop_front();
                if (got.distance != want.distance)
                    report_mismatch("wall_distance", got.distance, want.distance);
                if (got.face != want.face)
                    report_mismatch("hit_face", got.face, want.face);
                if (got.ceiling != want.ceiling)
                    report_mismatch("ceiling_row", $signed(got.ceiling),
                                    $signed(want.ceiling));
                if (got.floor_r != want.floor_r)
                    report_mismatch("floor_row", got.floor_r, want.floor_r);
                if (got.shade != want.shade)
                    report_mismatch("shade_code", got.shade, want.shade);
                if (got.near != want.near)
                    report_mismatch("near_wall", got.near, want.near);
                if (got.edge_f != want.edge_f)
                    report_mismatch("column_edge", got.edge_f, want.edge_f);
            end
        end
    end

    // The receiver stalls at random, or for a long stretch when asked to hold off.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset defaults of the block: the eye in cell (1,1), facing half a turn.
    task automatic test_defaults();
        cast_column(0);
        cast_column(64);
        cast_column(127);
        write_cell(1, 4, 1'b1);
        write_cell(4, 1, 1'b1);
        cast_column(63);
        cast_column(64);
    endtask

    // Walls on all four sides of the eye give every face; a wall in the eye cell
    // itself gives a hit with no face.
    task automatic test_faces();
        set_view(16 * 256 + 128, 16 * 256 + 128, 0, 64, 26, 9216);
        write_cell(18, 16, 1'b1);
        write_cell(14, 16, 1'b1);
        write_cell(16, 18, 1'b1);
        write_cell(16, 14, 1'b1);
        cast_column(64);
        wait_idle();
        write_register(CFG_VIEW_ANGLE, 256);
        cast_column(64);
        wait_idle();
        write_register(CFG_VIEW_ANGLE, 512);
        cast_column(64);
        wait_idle();
        write_register(CFG_VIEW_ANGLE, 768);
        cast_column(64);
        write_cell(16, 16, 1'b1);
        cast_column(10);
        write_cell(16, 16, 1'b0);
    endtask

    // Register extremes: zero step and zero depth, widest and narrowest views,
    // the map corners and the slowest possible march.
    task automatic test_extremes();
        set_view(0, 0, 1023, 511, 0, 0);
        cast_column(0);
        cast_column(127);
        set_view(16383, 16383, 0, 0, 255, 16383);
        cast_column(1);
        cast_column(126);
        set_view(32 * 256, 32 * 256, 100, 1, 1, 16383);
        cast_column(64);
        set_view(256, 256, 512, 64, 26, 256);
        cast_column(127);
    endtask

    // The receiver holds off while casts keep arriving, so the block backs up.
    task automatic test_backpressure();
        int k;
        set_view(20 * 256, 20 * 256, 300, 200, 255, 512);
        tx_idle = 0;
        @(negedge i_clk);
        hold_cycles = 3000;
        for (k = 0; k < 10; k++) cast_column($urandom_range(127));
    endtask

    // Random wall writes interleaved with mostly casts, under a random view.
    task automatic test_random_room(int sender_idle, int receiver_idle, int count);
        int k, dep;
        wait_idle();
        tx_idle = sender_idle;
        rx_idle = receiver_idle;
        dep = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(256, 9216);
        set_view($urandom_range(16383), $urandom_range(16383), $urandom_range(1023),
                 $urandom_range(511), $urandom_range(8, 255), dep);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 35)
                write_cell($urandom_range(63), $urandom_range(63), $urandom_range(99) < 40);
            else
                cast_column($urandom_range(127));
        end
    endtask

    initial begin
        int p;
        eye_x = 256;
        eye_y = 256;
        facing = 512;
        view_span = 64;
        step_size = 26;
        depth_lim = 9216;
        last_face = FACE_NONE;
        for (p = 0; p < 4096; p++) wall_cells[p] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_faces();
        test_extremes();
        test_backpressure();
        for (p = 0; p < 3; p++) test_random_room(14, 85, 70);
        for (p = 0; p < 3; p++) test_random_room(85, 14, 70);
        for (p = 0; p < 3; p++) test_random_room(0, 0, 70);

        wait_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
